/* rtl/complementary_attitude_estimator_unit_macros.svh */
// Assertion macros for the attitude estimator
`ifndef COMPLEMENTARY_ATTITUDE_ESTIMATOR_UNIT_MACROS_SVH
`define COMPLEMENTARY_ATTITUDE_ESTIMATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define CAE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CAE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CAE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CAE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/cae_pkg.sv */
package cae_pkg;

   localparam int ITER_W = 5;
   localparam int CW = 56;
   localparam int ZW = 34;
   localparam int RUN1_LEN = 32;

   localparam logic signed [ZW-1:0] DEG90 = 34'sd5898240;
   localparam logic signed [ZW-1:0] DEG180 = 34'sd11796480;
   localparam logic signed [ZW-1:0] DEG360 = 34'sd23592960;
   localparam logic [24:0] HEADING_MAX = 25'd23592959;
   localparam logic signed [CW-1:0] KINV_Q30 = 56'sd652032874;

   localparam logic [30:0] DIV_RECIP = 31'd1125899906;
   localparam logic [13:0] DIV_BASE = 14'd15625;
   localparam logic signed [39:0] DIV_HALF = 40'sd7812;
   localparam logic signed [39:0] DIV_BIAS = 40'sd15624;
   localparam logic [ITER_W-1:0] DIV_MUL_STEP = 5'd0;
   localparam logic [ITER_W-1:0] DIV_SUM_STEP = 5'd1;
   localparam logic [ITER_W-1:0] DIV_FIX_STEP = 5'd2;

   localparam logic [1:0] CSR_GYRO_WEIGHT = 2'd0;
   localparam logic [1:0] CSR_ACCEL_WEIGHT = 2'd1;
   localparam logic [1:0] CSR_YAW_PULL_GAIN = 2'd2;

   typedef struct packed {
      logic [15:0] accel_x;
      logic [15:0] accel_y;
      logic [15:0] accel_z;
      logic [15:0] rate_x;
      logic [15:0] rate_y;
      logic [15:0] rate_z;
      logic [15:0] field_x;
      logic [15:0] field_y;
      logic [15:0] field_z;
      logic [15:0] step_us;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] roll_deg;
      logic [31:0] pitch_deg;
      logic [31:0] yaw_deg;
      logic [24:0] heading_deg;
   } rsp_payload_type;

   typedef struct packed {
      logic load_item;
      logic prep;
      logic init_first;
      logic step_first;
      logic init_pitch;
      logic cordic_step;
      logic blend;
      logic reduce_q;
      logic reduce_load;
      logic save_trig;
      logic sel;
      logic mul_a;
      logic mul_b;
      logic init_head;
      logic head;
      logic pull;
      logic yaw_upd;
      logic out_load;
      logic [ITER_W-1:0] iter;
   } cmd_type;

   function automatic logic [21:0] atan_entry(input logic [ITER_W-1:0] idx);
      case (idx)
         5'd0: return 22'd2949120;
         5'd1: return 22'd1740967;
         5'd2: return 22'd919879;
         5'd3: return 22'd466945;
         5'd4: return 22'd234379;
         5'd5: return 22'd117304;
         5'd6: return 22'd58666;
         5'd7: return 22'd29335;
         5'd8: return 22'd14668;
         5'd9: return 22'd7334;
         5'd10: return 22'd3667;
         5'd11: return 22'd1833;
         5'd12: return 22'd917;
         5'd13: return 22'd458;
         5'd14: return 22'd229;
         5'd15: return 22'd115;
         5'd16: return 22'd57;
         5'd17: return 22'd29;
         5'd18: return 22'd14;
         5'd19: return 22'd7;
         5'd20: return 22'd4;
         5'd21: return 22'd2;
         5'd22: return 22'd1;
         default: return 22'd0;
      endcase
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return 32'(v);
   endfunction

endpackage

/* rtl/cae_channels.sv */
interface cae_req_if;
   logic valid;
   logic ready;
   logic [15:0] accel_x;
   logic [15:0] accel_y;
   logic [15:0] accel_z;
   logic [15:0] rate_x;
   logic [15:0] rate_y;
   logic [15:0] rate_z;
   logic [15:0] field_x;
   logic [15:0] field_y;
   logic [15:0] field_z;
   logic [15:0] step_us;
   modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
      field_x, field_y, field_z, step_us, input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
      field_x, field_y, field_z, step_us, output ready);
endinterface

interface cae_rsp_if;
   logic valid;
   logic ready;
   logic [31:0] roll_deg;
   logic [31:0] pitch_deg;
   logic [31:0] yaw_deg;
   logic [24:0] heading_deg;
   modport source (output valid, roll_deg, pitch_deg, yaw_deg, heading_deg, input ready);
   modport sink (input valid, roll_deg, pitch_deg, yaw_deg, heading_deg, output ready);
endinterface

/* rtl/cae_ctrl.sv */
module cae_ctrl #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   output cae_pkg::cmd_type cmd
);

   typedef enum logic [18:0] {
      S_IDLE  = 19'h00001,
      S_PREP  = 19'h00002,
      S_INIT  = 19'h00004,
      S_RUN1  = 19'h00008,
      S_PINIT = 19'h00010,
      S_PRUN  = 19'h00020,
      S_BLEND = 19'h00040,
      S_RED1  = 19'h00080,
      S_RED2  = 19'h00100,
      S_ROT   = 19'h00200,
      S_SAVE  = 19'h00400,
      S_MULA  = 19'h00800,
      S_MULB  = 19'h01000,
      S_HINIT = 19'h02000,
      S_HRUN  = 19'h04000,
      S_HEAD  = 19'h08000,
      S_PULL  = 19'h10000,
      S_YAW   = 19'h20000,
      S_OUT   = 19'h40000
   } state_type;

   state_type state_ff, state_in;
   logic [cae_pkg::ITER_W-1:0] iter_ff, iter_in;
   logic sel_ff, sel_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic cordic_last, run1_last, out_load;

   assign cordic_last = (iter_ff == cae_pkg::ITER_W'(CORDIC_STEPS - 1));
   assign run1_last = (iter_ff == cae_pkg::ITER_W'(cae_pkg::RUN1_LEN - 1));
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      iter_in = '0;
      sel_in = sel_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_PREP;
         end
         S_PREP: state_in = S_INIT;
         S_INIT: state_in = S_RUN1;
         S_RUN1: begin
            iter_in = iter_ff + 1'b1;
            if (run1_last) state_in = S_PINIT;
         end
         S_PINIT: state_in = S_PRUN;
         S_PRUN: begin
            iter_in = iter_ff + 1'b1;
            if (cordic_last) state_in = S_BLEND;
         end
         S_BLEND: begin
            sel_in = 1'b0;
            state_in = S_RED1;
         end
         S_RED1: state_in = S_RED2;
         S_RED2: state_in = S_ROT;
         S_ROT: begin
            iter_in = iter_ff + 1'b1;
            if (cordic_last) state_in = S_SAVE;
         end
         S_SAVE: begin
            if (!sel_ff) begin
               sel_in = 1'b1;
               state_in = S_RED1;
            end else begin
               state_in = S_MULA;
            end
         end
         S_MULA: state_in = S_MULB;
         S_MULB: state_in = S_HINIT;
         S_HINIT: state_in = S_HRUN;
         S_HRUN: begin
            iter_in = iter_ff + 1'b1;
            if (cordic_last) state_in = S_HEAD;
         end
         S_HEAD: state_in = S_PULL;
         S_PULL: state_in = S_YAW;
         S_YAW: state_in = S_OUT;
         S_OUT: begin
            if (out_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_comb begin
      cmd = '0;
      cmd.load_item = (state_ff == S_IDLE) && req_valid;
      cmd.prep = (state_ff == S_PREP);
      cmd.init_first = (state_ff == S_INIT);
      cmd.step_first = (state_ff == S_RUN1);
      cmd.init_pitch = (state_ff == S_PINIT);
      cmd.cordic_step = (state_ff == S_RUN1) || (state_ff == S_PRUN) ||
                        (state_ff == S_ROT) || (state_ff == S_HRUN);
      cmd.blend = (state_ff == S_BLEND);
      cmd.reduce_q = (state_ff == S_RED1);
      cmd.reduce_load = (state_ff == S_RED2);
      cmd.save_trig = (state_ff == S_SAVE);
      cmd.sel = sel_ff;
      cmd.mul_a = (state_ff == S_MULA);
      cmd.mul_b = (state_ff == S_MULB);
      cmd.init_head = (state_ff == S_HINIT);
      cmd.head = (state_ff == S_HEAD);
      cmd.pull = (state_ff == S_PULL);
      cmd.yaw_upd = (state_ff == S_YAW);
      cmd.out_load = out_load;
      cmd.iter = iter_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         iter_ff <= '0;
         sel_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         iter_ff <= iter_in;
         sel_ff <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/cae_dp.sv */
module cae_dp #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic clock,
   input  logic reset,
   input  cae_pkg::cmd_type cmd,
   input  logic csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_write_data,
   input  cae_pkg::req_payload_type req_data,
   output cae_pkg::rsp_payload_type rsp_data
);

   localparam int CW = cae_pkg::CW;
   localparam int ZW = cae_pkg::ZW;

   logic [15:0] gyro_weight_ff, accel_weight_ff, yaw_pull_gain_ff;
   cae_pkg::req_payload_type item_ff;
   cae_pkg::rsp_payload_type out_ff;

   logic signed [32:0] rate_prod_ff [3];
   logic signed [39:0] div_num [3];
   logic [36:0] div_mag_ff [3];
   logic [49:0] div_hi_ff [3];
   logic [48:0] div_lo_ff [3];
   logic [67:0] div_sum [3];
   logic [37:0] div_rem [3];
   logic [24:0] div_quo_ff [3];
   logic div_neg_ff [3];
   logic signed [15:0] rate_lane [3];
   logic signed [25:0] inc_lane [3];

   logic [31:0] mag_sq_ff;
   logic [63:0] sq_rad_ff;
   logic [33:0] sq_rem_ff;
   logic [31:0] sq_root_ff;
   logic [35:0] sq_rem2, sq_trial;

   logic signed [CW-1:0] cx_ff, cy_ff, cx_in, cy_in;
   logic signed [ZW-1:0] cz_ff, cz_in;
   logic c_rot_ff, c_zero_ff, c_neg_ff;
   logic signed [CW-1:0] dx, dy;
   logic signed [ZW-1:0] tab_s, c_ang;
   logic cordic_go, dir;

   logic signed [CW-1:0] vin_x, vin_y, vl_x, vl_y;
   logic signed [ZW-1:0] vl_z;

   logic signed [ZW-1:0] acc_roll_ff;
   logic signed [31:0] roll_ff, pitch_ff, yaw_ff;

   logic signed [31:0] red_a;
   logic signed [32:0] red_a_ext;
   logic [31:0] red_mag, red_mag_ff;
   logic red_neg_ff;
   logic [7:0] red_q_ff;
   logic [27:0] red_qprod;
   logic [32:0] red_sub;
   logic signed [ZW-1:0] red_m;
   logic red_flip;

   logic signed [ZW-1:0] cr_ff, sr_ff, cp_ff, sp_ff, p1_ff, p2_ff;
   logic signed [CW-1:0] trig_out;
   logic signed [67:0] pa1, pa2;
   logic signed [49:0] t1_ff, t2_ff, t3_ff, t4_ff, t5_ff;

   logic signed [51:0] blend_r, blend_p;
   logic signed [35:0] blend_r_rnd, blend_p_rnd;

   logic signed [ZW-1:0] head_h;
   logic [24:0] heading_ff;
   logic signed [34:0] pull_diff;
   logic signed [51:0] pull_prod_ff;
   logic signed [35:0] pull_rnd;
   logic signed [31:0] yaw_sat;
   logic signed [ZW-1:0] yaw_norm;

   assign rate_lane[0] = $signed(item_ff.rate_x);
   assign rate_lane[1] = $signed(item_ff.rate_y);
   assign rate_lane[2] = $signed(item_ff.rate_z);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         div_num[k] = 40'($signed({rate_prod_ff[k], 6'b000000})) + cae_pkg::DIV_HALF;
         div_sum[k] = {div_hi_ff[k], 18'b0} + 68'(div_lo_ff[k]);
         div_rem[k] = {1'b0, div_mag_ff[k]} -
                      38'(div_quo_ff[k]) * 38'(cae_pkg::DIV_BASE);
         inc_lane[k] = div_neg_ff[k] ? -$signed({1'b0, div_quo_ff[k]})
                                     : $signed({1'b0, div_quo_ff[k]});
      end
   end

   // square root digit step
   assign sq_rem2 = {sq_rem_ff, sq_rad_ff[63:62]};
   assign sq_trial = {2'b00, sq_root_ff, 2'b01};

   // cordic micro-rotation
   assign cordic_go = cmd.cordic_step && (cmd.iter < cae_pkg::ITER_W'(CORDIC_STEPS));
   assign dx = cx_ff >>> cmd.iter;
   assign dy = cy_ff >>> cmd.iter;
   assign tab_s = $signed({12'b0, cae_pkg::atan_entry(cmd.iter)});
   assign c_ang = c_zero_ff ? '0 : cz_ff;

   always_comb begin
      if (c_rot_ff) begin
         dir = !cz_ff[ZW-1];
         cx_in = dir ? cx_ff - dy : cx_ff + dy;
         cy_in = dir ? cy_ff + dx : cy_ff - dx;
         cz_in = dir ? cz_ff - tab_s : cz_ff + tab_s;
      end else begin
         dir = (cy_ff > 0);
         cx_in = dir ? cx_ff + dy : cx_ff - dy;
         cy_in = dir ? cy_ff - dx : cy_ff + dx;
         cz_in = dir ? cz_ff + tab_s : cz_ff - tab_s;
      end
   end

   // vectoring operands and half-plane fold
   always_comb begin
      vin_y = CW'($signed({item_ff.accel_y, 16'h0000}));
      vin_x = CW'($signed({item_ff.accel_z, 16'h0000}));
      if (cmd.init_pitch) begin
         vin_y = -CW'($signed({item_ff.accel_x, 16'h0000}));
         vin_x = CW'($signed({1'b0, sq_root_ff}));
      end else if (cmd.init_head) begin
         vin_x = CW'(t1_ff) + CW'(t2_ff);
         vin_y = CW'(t3_ff) + CW'(t4_ff) - CW'(t5_ff);
      end
      vl_x = vin_x;
      vl_y = vin_y;
      vl_z = '0;
      if (vin_x[CW-1]) begin
         if (!vin_y[CW-1]) begin
            vl_x = vin_y;
            vl_y = -vin_x;
            vl_z = cae_pkg::DEG90;
         end else begin
            vl_x = -vin_y;
            vl_y = vin_x;
            vl_z = -cae_pkg::DEG90;
         end
      end
   end

   // angle reduction to +-90 degrees
   assign red_a = cmd.sel ? pitch_ff : roll_ff;
   assign red_a_ext = 33'(red_a);
   assign red_mag = red_a[31] ? 32'(-red_a_ext) : 32'(red_a_ext);
   assign red_qprod = 28'(red_mag[31:19]) * 28'd23302;
   assign red_sub = {1'b0, red_mag_ff} - 33'(red_q_ff) * 33'd23592960;

   always_comb begin
      red_m = $signed({9'b0, red_sub[24:0]});
      if (red_neg_ff) red_m = -red_m;
      if (red_m >= cae_pkg::DEG180) red_m = red_m - cae_pkg::DEG360;
      if (red_m < -cae_pkg::DEG180) red_m = red_m + cae_pkg::DEG360;
      red_flip = 1'b0;
      if (red_m > cae_pkg::DEG90) begin
         red_m = red_m - cae_pkg::DEG180;
         red_flip = 1'b1;
      end else if (red_m < -cae_pkg::DEG90) begin
         red_m = red_m + cae_pkg::DEG180;
         red_flip = 1'b1;
      end
   end

   assign trig_out = c_neg_ff ? -cx_ff : cx_ff;
   assign pa1 = 68'(sr_ff) * 68'(sp_ff);
   assign pa2 = 68'(sr_ff) * 68'(cp_ff);

   // complementary blend
   assign blend_r = 52'($signed({1'b0, gyro_weight_ff})) * 52'(roll_ff) +
                    52'($signed({1'b0, accel_weight_ff})) * 52'(acc_roll_ff);
   assign blend_p = 52'($signed({1'b0, gyro_weight_ff})) * 52'(pitch_ff) +
                    52'($signed({1'b0, accel_weight_ff})) * 52'(c_ang);
   assign blend_r_rnd = 36'((blend_r + 52'sd32768) >>> 16);
   assign blend_p_rnd = 36'((blend_p + 52'sd32768) >>> 16);

   // heading and yaw pull
   always_comb begin
      head_h = c_ang;
      if (head_h < 0) head_h = head_h + cae_pkg::DEG360;
      if (head_h < 0) head_h = '0;
      if (head_h > $signed({9'b0, cae_pkg::HEADING_MAX}))
         head_h = $signed({9'b0, cae_pkg::HEADING_MAX});
   end

   always_comb begin
      pull_diff = $signed({10'b0, heading_ff}) - 35'(yaw_ff);
      if (pull_diff > 35'(cae_pkg::DEG180)) pull_diff = pull_diff - 35'(cae_pkg::DEG360);
      if (pull_diff < -35'(cae_pkg::DEG180)) pull_diff = pull_diff + 35'(cae_pkg::DEG360);
   end

   assign pull_rnd = 36'((pull_prod_ff + 52'sd32768) >>> 16);
   assign yaw_sat = cae_pkg::sat32(64'(yaw_ff) + 64'(pull_rnd));

   always_comb begin
      yaw_norm = ZW'(yaw_sat);
      if (yaw_norm < 0) yaw_norm = yaw_norm + cae_pkg::DEG360;
      if (yaw_norm >= cae_pkg::DEG360) yaw_norm = yaw_norm - cae_pkg::DEG360;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gyro_weight_ff <= 16'd64225;
         accel_weight_ff <= 16'd1311;
         yaw_pull_gain_ff <= 16'd655;
      end else if (csr_write_enable) begin
         case (csr_index)
            cae_pkg::CSR_GYRO_WEIGHT: gyro_weight_ff <= csr_write_data;
            cae_pkg::CSR_ACCEL_WEIGHT: accel_weight_ff <= csr_write_data;
            cae_pkg::CSR_YAW_PULL_GAIN: yaw_pull_gain_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_ff <= '0;
         pitch_ff <= '0;
         yaw_ff <= '0;
      end else if (cmd.init_pitch) begin
         roll_ff <= cae_pkg::sat32(64'(roll_ff) + 64'(inc_lane[0]));
         pitch_ff <= cae_pkg::sat32(64'(pitch_ff) + 64'(inc_lane[1]));
         yaw_ff <= cae_pkg::sat32(64'(yaw_ff) + 64'(inc_lane[2]));
      end else if (cmd.blend) begin
         roll_ff <= cae_pkg::sat32(64'(blend_r_rnd));
         pitch_ff <= cae_pkg::sat32(64'(blend_p_rnd));
      end else if (cmd.yaw_upd) begin
         yaw_ff <= 32'(yaw_norm);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) item_ff <= req_data;

      if (cmd.prep) begin
         for (int k = 0; k < 3; k++) begin
            rate_prod_ff[k] <= 33'(rate_lane[k]) * $signed({17'b0, item_ff.step_us});
         end
         mag_sq_ff <= 32'(32'($signed(item_ff.accel_y)) * 32'($signed(item_ff.accel_y))) +
                      32'(32'($signed(item_ff.accel_z)) * 32'($signed(item_ff.accel_z)));
      end

      // reciprocal estimate of the quotient, then one correction
      for (int k = 0; k < 3; k++) begin
         if (cmd.init_first) begin
            div_neg_ff[k] <= div_num[k][39];
            div_quo_ff[k] <= '0;
            if (div_num[k][39])
               div_mag_ff[k] <= 37'(-div_num[k] + cae_pkg::DIV_BIAS);
            else
               div_mag_ff[k] <= 37'(div_num[k]);
         end else if (cmd.step_first) begin
            if (cmd.iter == cae_pkg::DIV_MUL_STEP) begin
               div_hi_ff[k] <= 50'(div_mag_ff[k][36:18]) * 50'(cae_pkg::DIV_RECIP);
               div_lo_ff[k] <= 49'(div_mag_ff[k][17:0]) * 49'(cae_pkg::DIV_RECIP);
            end else if (cmd.iter == cae_pkg::DIV_SUM_STEP) begin
               div_quo_ff[k] <= {1'b0, div_sum[k][67:44]};
            end else if ((cmd.iter == cae_pkg::DIV_FIX_STEP) &&
                         (div_rem[k] >= 38'(cae_pkg::DIV_BASE))) begin
               div_quo_ff[k] <= div_quo_ff[k] + 1'b1;
            end
         end
      end

      if (cmd.init_first) begin
         sq_rad_ff <= {mag_sq_ff, 32'h0};
         sq_rem_ff <= '0;
         sq_root_ff <= '0;
      end else if (cmd.step_first) begin
         sq_rad_ff <= {sq_rad_ff[61:0], 2'b00};
         if (sq_rem2 >= sq_trial) begin
            sq_rem_ff <= 34'(sq_rem2 - sq_trial);
            sq_root_ff <= {sq_root_ff[30:0], 1'b1};
         end else begin
            sq_rem_ff <= 34'(sq_rem2);
            sq_root_ff <= {sq_root_ff[30:0], 1'b0};
         end
      end

      if (cmd.init_first || cmd.init_pitch || cmd.init_head) begin
         cx_ff <= vl_x;
         cy_ff <= vl_y;
         cz_ff <= vl_z;
         c_rot_ff <= 1'b0;
         c_zero_ff <= (vin_x == 0) && (vin_y == 0);
      end else if (cmd.reduce_load) begin
         cx_ff <= cae_pkg::KINV_Q30;
         cy_ff <= '0;
         cz_ff <= red_m;
         c_rot_ff <= 1'b1;
         c_zero_ff <= 1'b0;
         c_neg_ff <= red_flip;
      end else if (cordic_go) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
      end

      if (cmd.init_pitch) acc_roll_ff <= c_ang;

      if (cmd.reduce_q) begin
         red_mag_ff <= red_mag;
         red_neg_ff <= red_a[31];
         red_q_ff <= red_qprod[27:20];
      end

      if (cmd.save_trig) begin
         if (!cmd.sel) begin
            cr_ff <= ZW'(trig_out);
            sr_ff <= ZW'(c_neg_ff ? -cy_ff : cy_ff);
         end else begin
            cp_ff <= ZW'(trig_out);
            sp_ff <= ZW'(c_neg_ff ? -cy_ff : cy_ff);
         end
      end

      if (cmd.mul_a) begin
         p1_ff <= ZW'(pa1 >>> 30);
         p2_ff <= ZW'(pa2 >>> 30);
      end

      if (cmd.mul_b) begin
         t1_ff <= 50'($signed(item_ff.field_x)) * 50'(cp_ff);
         t2_ff <= 50'($signed(item_ff.field_z)) * 50'(sp_ff);
         t3_ff <= 50'($signed(item_ff.field_x)) * 50'(p1_ff);
         t4_ff <= 50'($signed(item_ff.field_y)) * 50'(cr_ff);
         t5_ff <= 50'($signed(item_ff.field_z)) * 50'(p2_ff);
      end

      if (cmd.head) heading_ff <= 25'(head_h);

      if (cmd.pull) pull_prod_ff <= 52'(pull_diff) * 52'($signed({1'b0, yaw_pull_gain_ff}));

      if (cmd.out_load) begin
         out_ff.roll_deg <= roll_ff;
         out_ff.pitch_deg <= pitch_ff;
         out_ff.yaw_deg <= yaw_ff;
         out_ff.heading_deg <= heading_ff;
      end
   end

   assign rsp_data = out_ff;

endmodule

/* rtl/complementary_attitude_estimator_unit.sv */
// channel   dir  handshake               payload
// req_item  in   valid/ready             accel, rate, field x/y/z, step_us
// rsp_item  out  valid/ready             roll, pitch, yaw, heading
// csr       in   csr_write_enable        csr_index, csr_write_data
//
// One item at a time: the time from accept to result is set by five passes through one
// shared CORDIC stage plus a root/divide phase that runs during the first pass.
// The output register holds a result while the next item is accepted and worked on.
// Synchronous reset clears the angles, restores default weights and empties the output.
// A stalled result stalls only the final load of the next one.

`include "complementary_attitude_estimator_unit_macros.svh"

module complementary_attitude_estimator_unit #(
   parameter int CORDIC_STEPS = 16
) (
   input logic clock,
   input logic reset,
   cae_req_if.sink req_item,
   cae_rsp_if.source rsp_item,
   input logic csr_write_enable,
   input logic [1:0] csr_index,
   input logic [15:0] csr_write_data
);

   cae_pkg::cmd_type cmd;
   cae_pkg::req_payload_type req_data;
   cae_pkg::rsp_payload_type rsp_data;

   always_comb begin
      req_data.accel_x = req_item.accel_x;
      req_data.accel_y = req_item.accel_y;
      req_data.accel_z = req_item.accel_z;
      req_data.rate_x = req_item.rate_x;
      req_data.rate_y = req_item.rate_y;
      req_data.rate_z = req_item.rate_z;
      req_data.field_x = req_item.field_x;
      req_data.field_y = req_item.field_y;
      req_data.field_z = req_item.field_z;
      req_data.step_us = req_item.step_us;
   end

   assign rsp_item.roll_deg = rsp_data.roll_deg;
   assign rsp_item.pitch_deg = rsp_data.pitch_deg;
   assign rsp_item.yaw_deg = rsp_data.yaw_deg;
   assign rsp_item.heading_deg = rsp_data.heading_deg;

   cae_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_item.valid),
      .req_ready(req_item.ready),
      .rsp_valid(rsp_item.valid),
      .rsp_ready(rsp_item.ready),
      .cmd(cmd)
   );

   cae_dp #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_data(req_data),
      .rsp_data(rsp_data)
   );

   `CAE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_item.valid && req_item.ready, !req_item.ready)
   `CAE_ASSERT_IMPLY(a_heading_bound, clock, reset, rsp_item.valid, rsp_item.heading_deg <= cae_pkg::HEADING_MAX)
   `CAE_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_item.valid)

endmodule

/* dv/cae_attitude_checker.sv */
module cae_attitude_checker
   import cae_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input logic clock,
   input logic reset,
   cae_req_if req_item,
   cae_rsp_if rsp_item,
   input logic csr_write_enable,
   input logic [1:0] csr_index,
   input logic [15:0] csr_write_data,
   output int mismatch_count,
   output int pending_count
);

   localparam longint ANGLE_360 = longint'(DEG360);
   localparam longint ANGLE_180 = longint'(DEG180);
   localparam longint ANGLE_90 = longint'(DEG90);

   longint arc_step [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   logic [15:0] gyro_gain;
   logic [15:0] accel_gain;
   logic [15:0] pull_gain;
   longint roll_q16;
   longint pitch_q16;
   longint yaw_q16;

   rsp_payload_type attitude_queue[$];

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint round_q16(input longint v);
      return (v + 32768) >>> 16;
   endfunction

   function automatic longint div_floor(input longint n, input longint d);
      if (n >= 0) return n / d;
      return -((-n + d - 1) / d);
   endfunction

   function automatic longint unsigned int_root(input longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint arc_angle(input longint y_in, input longint x_in);
      longint x, y, z, t, dx, dy;
      x = x_in;
      y = y_in;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = ANGLE_90;
         end else begin
            t = x; x = -y; y = t; z = -ANGLE_90;
         end
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (y > 0) begin
            x += dy; y -= dx; z += arc_step[i];
         end else begin
            x -= dy; y += dx; z -= arc_step[i];
         end
      end
      return z;
   endfunction

   function automatic void rotate_unit(input longint ang, output longint c, output longint s);
      longint m, x, y, dx, dy;
      bit flip;
      m = ang % ANGLE_360;
      x = longint'(KINV_Q30);
      y = 0;
      flip = 0;
      if (m >= ANGLE_180) m -= ANGLE_360;
      if (m < -ANGLE_180) m += ANGLE_360;
      if (m > ANGLE_90) begin
         m -= ANGLE_180; flip = 1;
      end else if (m < -ANGLE_90) begin
         m += ANGLE_180; flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (m >= 0) begin
            x -= dy; y += dx; m -= arc_step[i];
         end else begin
            x += dy; y -= dx; m += arc_step[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic rsp_payload_type advance_attitude(input req_payload_type p);
      longint ax, ay, az, rx, ry, rz, fx, fy, fz, dt;
      longint tilt_roll, tilt_pitch, root, cr, sr, cp, sp, mx, my, heading, diff, yaw;
      rsp_payload_type r;
      ax = longint'($signed(p.accel_x));
      ay = longint'($signed(p.accel_y));
      az = longint'($signed(p.accel_z));
      rx = longint'($signed(p.rate_x));
      ry = longint'($signed(p.rate_y));
      rz = longint'($signed(p.rate_z));
      fx = longint'($signed(p.field_x));
      fy = longint'($signed(p.field_y));
      fz = longint'($signed(p.field_z));
      dt = longint'(p.step_us);

      tilt_roll = arc_angle(ay * 65536, az * 65536);
      root = longint'(int_root(longint'(unsigned'(ay * ay + az * az)) << 32));
      tilt_pitch = arc_angle(-ax * 65536, root);

      roll_q16 = clamp32(roll_q16 + div_floor(rx * dt * 4096 + 500000, 1000000));
      pitch_q16 = clamp32(pitch_q16 + div_floor(ry * dt * 4096 + 500000, 1000000));
      yaw_q16 = clamp32(yaw_q16 + div_floor(rz * dt * 4096 + 500000, 1000000));

      roll_q16 = clamp32(round_q16(longint'(gyro_gain) * roll_q16 +
                                   longint'(accel_gain) * tilt_roll));
      pitch_q16 = clamp32(round_q16(longint'(gyro_gain) * pitch_q16 +
                                    longint'(accel_gain) * tilt_pitch));

      rotate_unit(roll_q16, cr, sr);
      rotate_unit(pitch_q16, cp, sp);
      mx = fx * cp + fz * sp;
      my = fx * ((sr * sp) >>> 30) + fy * cr - fz * ((sr * cp) >>> 30);
      heading = arc_angle(my, mx);
      if (heading < 0) heading += ANGLE_360;
      if (heading < 0) heading = 0;
      if (heading > ANGLE_360 - 1) heading = ANGLE_360 - 1;

      diff = heading - yaw_q16;
      if (diff > ANGLE_180) diff -= ANGLE_360;
      if (diff < -ANGLE_180) diff += ANGLE_360;
      yaw = clamp32(yaw_q16 + round_q16(diff * longint'(pull_gain)));
      if (yaw < 0) yaw += ANGLE_360;
      if (yaw >= ANGLE_360) yaw -= ANGLE_360;
      yaw_q16 = clamp32(yaw);

      r.roll_deg = roll_q16[31:0];
      r.pitch_deg = pitch_q16[31:0];
      r.yaw_deg = yaw_q16[31:0];
      r.heading_deg = heading[24:0];
      return r;
   endfunction

   assign pending_count = attitude_queue.size();

   always @(posedge clock) begin
      req_payload_type sample;
      rsp_payload_type seen;
      rsp_payload_type want;
      if (reset) begin
         gyro_gain <= 16'd64225;
         accel_gain <= 16'd1311;
         pull_gain <= 16'd655;
         roll_q16 = 0;
         pitch_q16 = 0;
         yaw_q16 = 0;
         attitude_queue.delete();
         mismatch_count <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_GYRO_WEIGHT: gyro_gain <= csr_write_data;
               CSR_ACCEL_WEIGHT: accel_gain <= csr_write_data;
               CSR_YAW_PULL_GAIN: pull_gain <= csr_write_data;
               default: ;
            endcase
         end
         if (req_item.valid && req_item.ready) begin
            sample.accel_x = req_item.accel_x;
            sample.accel_y = req_item.accel_y;
            sample.accel_z = req_item.accel_z;
            sample.rate_x = req_item.rate_x;
            sample.rate_y = req_item.rate_y;
            sample.rate_z = req_item.rate_z;
            sample.field_x = req_item.field_x;
            sample.field_y = req_item.field_y;
            sample.field_z = req_item.field_z;
            sample.step_us = req_item.step_us;
            attitude_queue.push_back(advance_attitude(sample));
         end
         if (rsp_item.valid && rsp_item.ready) begin
            seen.roll_deg = rsp_item.roll_deg;
            seen.pitch_deg = rsp_item.pitch_deg;
            seen.yaw_deg = rsp_item.yaw_deg;
            seen.heading_deg = rsp_item.heading_deg;
            if (attitude_queue.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected item: roll %h pitch %h yaw %h heading %h",
                     seen.roll_deg, seen.pitch_deg, seen.yaw_deg, seen.heading_deg);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = attitude_queue.pop_front();
               if (seen !== want) begin
                  if (mismatch_count < 10)
                     $display("mismatch: exp roll %h pitch %h yaw %h heading %h, got %h %h %h %h",
                        want.roll_deg, want.pitch_deg, want.yaw_deg, want.heading_deg,
                        seen.roll_deg, seen.pitch_deg, seen.yaw_deg, seen.heading_deg);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end

endmodule

/* dv/tb.sv */
module tb;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [1:0] csr_index;
   logic [15:0] csr_write_data;
   int mismatch_count;
   int pending_count;
   int rsp_taken;
   bit quiet_send;
   bit quiet_take;

   cae_req_if req_item();
   cae_rsp_if rsp_item();

   complementary_attitude_estimator_unit u_dut (
      .clock(clock),
      .reset(reset),
      .req_item(req_item),
      .rsp_item(rsp_item),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   cae_attitude_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_item(req_item),
      .rsp_item(rsp_item),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .mismatch_count(mismatch_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #60000000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_sample(input cae_pkg::req_payload_type p);
      int gap;
      gap = quiet_send ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_item.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item.valid <= 1'b1;
      req_item.accel_x <= p.accel_x;
      req_item.accel_y <= p.accel_y;
      req_item.accel_z <= p.accel_z;
      req_item.rate_x <= p.rate_x;
      req_item.rate_y <= p.rate_y;
      req_item.rate_z <= p.rate_z;
      req_item.field_x <= p.field_x;
      req_item.field_y <= p.field_y;
      req_item.field_z <= p.field_z;
      req_item.step_us <= p.step_us;
      @(posedge clock);
      while (!req_item.ready) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain;
      req_item.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (130) @(posedge clock);
   endtask

   function automatic cae_pkg::req_payload_type make_sample(input logic [15:0] ax, ay, az,
      rx, ry, rz, fx, fy, fz, dt);
      cae_pkg::req_payload_type p;
      p = '{ax, ay, az, rx, ry, rz, fx, fy, fz, dt};
      return p;
   endfunction

   function automatic cae_pkg::req_payload_type random_sample();
      cae_pkg::req_payload_type p;
      int mode;
      mode = $urandom_range(0, 9);
      p = {$urandom, $urandom, $urandom, $urandom, $urandom};
      if (mode < 7) begin
         p.accel_x = 16'($signed($urandom_range(0, 8192)) - 4096);
         p.accel_y = 16'($signed($urandom_range(0, 8192)) - 4096);
         p.accel_z = 16'($signed($urandom_range(0, 4096)) + 2048);
         p.rate_x = 16'($signed($urandom_range(0, 8000)) - 4000);
         p.rate_y = 16'($signed($urandom_range(0, 8000)) - 4000);
         p.rate_z = 16'($signed($urandom_range(0, 8000)) - 4000);
         p.step_us = 16'($urandom_range(500, 20000));
      end
      return p;
   endfunction

   task automatic run_random(input int count);
      for (int n = 0; n < count; n++) begin
         quiet_send = ((n / 60) % 4) == 3;
         send_sample(random_sample());
      end
      drain();
   endtask

   initial begin
      rsp_item.ready <= 1'b0;
      rsp_taken = 0;
      @(negedge reset);
      forever begin
         int stall;
         quiet_take = ((rsp_taken / 70) % 4) == 2;
         stall = quiet_take ? 0 : $urandom_range(0, 11);
         if (rsp_taken == 400) stall = 1500;
         if (stall > 0) begin
            rsp_item.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_item.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_item.valid) @(posedge clock);
         rsp_taken++;
      end
   end

   initial begin
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= cae_pkg::CSR_GYRO_WEIGHT;
      csr_write_data <= '0;
      quiet_send = 0;
      req_item.valid <= 1'b0;
      req_item.accel_x <= '0;
      req_item.accel_y <= '0;
      req_item.accel_z <= '0;
      req_item.rate_x <= '0;
      req_item.rate_y <= '0;
      req_item.rate_z <= '0;
      req_item.field_x <= '0;
      req_item.field_y <= '0;
      req_item.field_z <= '0;
      req_item.step_us <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_sample(make_sample(0, 0, 4096, 160, -160, 320, 300, 0, 0, 0));
      send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
         16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF));
      send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
         16'h8000, 16'h8000, 16'h8000, 16'hFFFF));
      send_sample(make_sample(-4096, 0, 0, 0, 0, 0, 0, 0, 0, 1000));
      send_sample(make_sample(4096, 100, -4096, 100, 100, -100, -200, 200, 0, 1000));
      send_sample(make_sample(0, 4096, 0, 0, 0, 0, 0, -300, 50, 1));
      send_sample(make_sample(0, -4096, -10, 0, 0, 0, -300, 0, 0, 2));
      send_sample(make_sample(0, 0, 4096, 0, 0, 0, -300, -1, 100, 0));
      send_sample(make_sample(0, 0, 4096, 0, 0, 0, 0, 0, 0, 100));
      for (int k = 0; k < 6; k++)
         send_sample(make_sample(0, 0, 4096, 16'h7FFF, 16'h8000, 16'h7FFF,
            100, 100, 100, 16'hFFFF));
      for (int k = 0; k < 4; k++)
         send_sample(make_sample(0, 0, 4096, 0, 0, 16'h8000, -100, -5, 0, 16'hFFFF));
      drain();

      run_random(500);

      write_csr(cae_pkg::CSR_GYRO_WEIGHT, 16'd0);
      write_csr(cae_pkg::CSR_ACCEL_WEIGHT, 16'd0);
      write_csr(cae_pkg::CSR_YAW_PULL_GAIN, 16'd0);
      run_random(200);

      write_csr(cae_pkg::CSR_GYRO_WEIGHT, 16'hFFFF);
      write_csr(cae_pkg::CSR_ACCEL_WEIGHT, 16'hFFFF);
      write_csr(cae_pkg::CSR_YAW_PULL_GAIN, 16'hFFFF);
      run_random(200);

      write_csr(cae_pkg::CSR_GYRO_WEIGHT, 16'($urandom));
      write_csr(cae_pkg::CSR_ACCEL_WEIGHT, 16'($urandom));
      write_csr(cae_pkg::CSR_YAW_PULL_GAIN, 16'($urandom));
      run_random(300);

      write_csr(cae_pkg::CSR_GYRO_WEIGHT, 16'd64225);
      write_csr(cae_pkg::CSR_ACCEL_WEIGHT, 16'd1311);
      write_csr(cae_pkg::CSR_YAW_PULL_GAIN, 16'd655);
      run_random(500);

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
